FILE: src/wdt_pkg.sv
// Package with the transaction types, register codes and constants of the watchdog.
package wdt_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] REG_LOAD  = 3'd0;
  localparam logic [2:0] REG_VALUE = 3'd1;
  localparam logic [2:0] REG_CTL   = 3'd2;
  localparam logic [2:0] REG_ICR   = 3'd3;
  localparam logic [2:0] REG_RIS   = 3'd4;
  localparam logic [2:0] REG_MIS   = 3'd5;
  localparam logic [2:0] REG_LOCK  = 3'd6;

  localparam logic [31:0] UNLOCK_KEY = 32'h1ACC_E551;

  localparam int CTL_INTEN_BIT   = 0;
  localparam int CTL_RESEN_BIT   = 1;
  localparam int CTL_WRC_BIT     = 31;
  localparam int RIS_TIMEOUT_BIT = 0;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_select;
    logic [31:0] write_data;
  } wdt_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt_out;
    logic        reset_request;
  } wdt_out_t;

endpackage

FILE: src/wdt_core.sv
// Watchdog register file, down-counter and single-transaction update logic.
module wdt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  wdt_pkg::wdt_in_t item,
  output wdt_pkg::wdt_out_t result
);
  import wdt_pkg::*;

  logic [COUNT_WIDTH-1:0] load_value, load_value_next;
  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic int_enable, int_enable_next;
  logic reset_enable, reset_enable_next;
  logic timeout_flag, timeout_flag_next;
  logic locked, locked_next;
  logic reset_latched, reset_latched_next;
  logic [31:0] rd;

  always_comb begin
    load_value_next    = load_value;
    count_value_next   = count_value;
    int_enable_next    = int_enable;
    reset_enable_next  = reset_enable;
    timeout_flag_next  = timeout_flag;
    locked_next        = locked;
    reset_latched_next = reset_latched;
    rd                 = '0;

    unique case (item.action)
      ACT_TICK: begin
        if (int_enable) begin
          if (count_value == '0) begin
            // second timeout with the flag still pending escalates to reset when RESEN is set
            if (timeout_flag && reset_enable) reset_latched_next = 1'b1;
            timeout_flag_next = 1'b1;
            count_value_next  = load_value;
          end else begin
            count_value_next = count_value - COUNT_WIDTH'(1);
          end
        end
      end
      ACT_WRITE: begin
        if (item.reg_select == REG_LOCK) begin
          locked_next = (item.write_data != UNLOCK_KEY);
        end else if (!locked) begin
          unique case (item.reg_select)
            REG_LOAD: begin
              load_value_next  = item.write_data[COUNT_WIDTH-1:0];
              count_value_next = item.write_data[COUNT_WIDTH-1:0];
            end
            REG_CTL: begin
              // INTEN is set-only
              if (item.write_data[CTL_INTEN_BIT]) int_enable_next = 1'b1;
              reset_enable_next = item.write_data[CTL_RESEN_BIT];
            end
            REG_ICR: begin
              timeout_flag_next = 1'b0;
              count_value_next  = load_value;
            end
            default: ;
          endcase
        end
      end
      ACT_READ: begin
        unique case (item.reg_select)
          REG_LOAD:  rd = 32'(load_value);
          REG_VALUE: rd = 32'(count_value);
          REG_CTL: begin
            rd[CTL_WRC_BIT]   = 1'b1;
            rd[CTL_RESEN_BIT] = reset_enable;
            rd[CTL_INTEN_BIT] = int_enable;
          end
          REG_RIS:  rd[RIS_TIMEOUT_BIT] = timeout_flag;
          REG_MIS:  rd[RIS_TIMEOUT_BIT] = timeout_flag & int_enable;
          REG_LOCK: rd[0] = locked;
          default:  rd = '0;
        endcase
      end
      default: ;
    endcase

    result.read_data     = rd;
    result.interrupt_out = timeout_flag_next & int_enable_next;
    result.reset_request = reset_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value    <= '1;
      count_value   <= '1;
      int_enable    <= 1'b0;
      reset_enable  <= 1'b0;
      timeout_flag  <= 1'b0;
      locked        <= 1'b0;
      reset_latched <= 1'b0;
    end else if (fire) begin
      load_value    <= load_value_next;
      count_value   <= count_value_next;
      int_enable    <= int_enable_next;
      reset_enable  <= reset_enable_next;
      timeout_flag  <= timeout_flag_next;
      locked        <= locked_next;
      reset_latched <= reset_latched_next;
    end
  end

endmodule

FILE: src/watchdog_timer_with_lock.sv
// Top level of the two-stage watchdog with lock: input register, core and result register.
//
// Usage: every input transaction (in_valid/in_stall, payload in_data) is a tick,
// a register write or a register read; each one yields exactly one result
// transaction (out_valid/out_stall, payload out_data) carrying read data, the
// masked interrupt level and the sticky reset request after that transaction.
// An accepted transaction waits in the input register until the result
// register can take it; the core then updates its state and the result register
// captures the outcome. Throughput is one transaction per cycle while the receiver
// does not stall, set by the single pass through the core between the two registers.
// When the receiver stalls, the result register holds its transaction; a
// transaction already in the input register waits there, and in_stall rises
// only while that register is occupied and cannot drain, so one more
// transaction is still taken while the result waits.
// Reset (rst, synchronous, active high) empties both stages and returns the
// registers to LOAD = VALUE = all ones, everything else cleared and unlocked.
module watchdog_timer_with_lock (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wdt_pkg::wdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wdt_pkg::wdt_out_t out_data
);
  import wdt_pkg::*;

  logic     stage_valid;
  wdt_in_t  stage_item;
  wdt_out_t core_result;
  logic     out_ready;
  logic     fire;
  logic     accept;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = stage_valid && out_ready;
  assign in_stall  = stage_valid && !out_ready;
  assign accept    = in_valid && !in_stall;

  wdt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // hold the input stage when the result side is blocked
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (fire) begin
        stage_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage_item <= in_data;
    if (fire)   out_data   <= core_result;
  end

endmodule
